>>> design/ik_pkg.sv
package ik_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int QDEPTH = 2;

  localparam int MUL_W = 30;
  localparam int PROD_W = 2 * MUL_W;
  localparam int ACC_W = 51;
  localparam int SQ_W = 51;
  localparam int ANG_W = 28;
  localparam int LH_W = 30;

  localparam logic signed [ANG_W-1:0] Q24_PI = 28'sd52707179;
  localparam logic signed [ANG_W-1:0] Q24_HALF_PI = 28'sd26353589;
  localparam logic signed [MUL_W-1:0] Q24_TWO_PI = 30'sd105414358;
  localparam logic [24:0] Q24_ONE = 25'd16777216;

  localparam logic [24:0] ATAN_TAB [24] = '{
    25'd13176795, 25'd7778716, 25'd4110060, 25'd2086331,
    25'd1047214, 25'd524117, 25'd262123, 25'd131069,
    25'd65536, 25'd32768, 25'd16384, 25'd8192,
    25'd4096, 25'd2048, 25'd1024, 25'd512,
    25'd256, 25'd128, 25'd64, 25'd32,
    25'd16, 25'd8, 25'd4, 25'd2
  };

  typedef struct packed {
    logic [13:0] upper;
    logic [13:0] lower;
    logic [11:0] lead;
    logic [14:0] reach;
    logic [14:0] park;
  } cfg_t;

  typedef struct packed {
    logic signed [16:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic               side;
  } item_t;

endpackage

>>> design/ik_front.sv
module ik_front
  import ik_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  logic                full,
  input  logic signed [15:0]  x_pos,
  input  logic signed [15:0]  y_pos,
  input  logic signed [15:0]  z_pos,
  input  cfg_t                cfg,
  output logic                q_push,
  output item_t               q_item
);

  logic side;
  logic side_next;
  logic y_low;

  always_comb begin
    y_low = y_pos < $signed({1'b0, cfg.reach});
    side_next = side;
    if (x_pos > 16'sd0 && y_low) side_next = 1'b0;
    if (x_pos > $signed({1'b0, cfg.park})) side_next = 1'b0;
    if (x_pos < 16'sd0 && y_low) side_next = 1'b1;
  end

  assign q_push = push && !full;

  always_comb begin
    q_item.x = side_next ? -17'(x_pos) : 17'(x_pos);
    q_item.y = y_pos;
    q_item.z = z_pos;
    q_item.side = side_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      side <= 1'b0;
    end else if (q_push) begin
      side <= side_next;
    end
  end

endmodule

>>> design/ik_queue.sv
module ik_queue
  import ik_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   wr_en,
  input  item_t  wr_item,
  output logic   full,
  input  logic   rd_en,
  output item_t  rd_item,
  output logic   empty
);

  localparam int PW = $clog2(QDEPTH);

  item_t mem [QDEPTH];
  logic [PW-1:0] wp;
  logic [PW-1:0] rp;
  logic [PW:0] count;
  logic do_wr;
  logic do_rd;

  assign full = count == (PW+1)'(QDEPTH);
  assign empty = count == '0;
  assign do_wr = wr_en && !full;
  assign do_rd = rd_en && !empty;
  assign rd_item = mem[rp];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wp] <= wr_item;
    end
    if (rst) begin
      wp <= '0;
      rp <= '0;
      count <= '0;
    end else begin
      if (do_wr) wp <= (wp == PW'(QDEPTH-1)) ? '0 : wp + 1'b1;
      if (do_rd) rp <= (rp == PW'(QDEPTH-1)) ? '0 : rp + 1'b1;
      if (do_wr && !do_rd) count <= count + 1'b1;
      else if (do_rd && !do_wr) count <= count - 1'b1;
    end
  end

endmodule

>>> design/ik_back.sv
module ik_back
  import ik_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  cfg_t                cfg,
  input  logic                q_empty,
  input  item_t               q_item,
  output logic                q_pop,
  input  logic                pop,
  output logic                out_valid,
  output logic signed [16:0]  shoulder_angle,
  output logic signed [16:0]  elbow_angle,
  output logic signed [31:0]  lift_rotation,
  output logic                elbow_flipped,
  output logic                reach_clamped,
  output logic                cosine_clamped
);

  typedef enum logic [4:0] {
    S_IDLE, S_SQX, S_SQY, S_SQRT, S_DCLAMP,
    S_N1A, S_N1B, S_N1C, S_DEN1,
    S_N2A, S_N2B, S_N2C, S_DEN2,
    S_ACHK, S_DIV, S_ACQ, S_ACSQ, S_ACCS,
    S_CINIT, S_CORD, S_CDONE, S_ANG,
    S_GEARM, S_GEARQ, S_LIFTM, S_LIFTQ, S_FIN
  } state_t;

  typedef enum logic [1:0] {CJ_D2, CJ_E, CJ_D1} cjob_t;
  typedef enum logic [1:0] {DJ_COS, DJ_LIFT} djob_t;

  localparam logic signed [ACC_W-1:0] ONE_SQ = 51'sd281474976710656;
  // ceil(2^36 / 31): floor(q * GEAR_RECIP / 2^36) == floor(q / 31) for q < 2^31
  localparam logic [31:0] GEAR_RECIP = 32'd2216757315;

  state_t state;
  cjob_t cjob;
  djob_t djob;

  logic signed [16:0] xs;
  logic signed [15:0] ys;
  logic signed [15:0] zs;
  logic side;
  logic reach_flag;
  logic cos_flag;

  logic [19:0] d;
  logic signed [ACC_W-1:0] acc;
  logic [39:0] den;
  logic signed [25:0] r;

  logic [SQ_W-1:0] sq_v;
  logic [SQ_W-1:0] sq_r;
  logic [SQ_W-1:0] sq_b;
  logic sq_first;

  logic [40:0] rem;
  logic [39:0] dvs;
  logic [41:0] ds;
  logic [5:0] dcnt;
  logic div_neg;

  logic [30:0] gear_q;
  logic [62:0] gear_prod;

  logic signed [28:0] cx;
  logic signed [28:0] cy;
  logic signed [ANG_W-1:0] cz;
  logic [4:0] ci;

  logic signed [ANG_W-1:0] d1;
  logic signed [ANG_W-1:0] d2;
  logic signed [ANG_W-1:0] e;
  logic signed [LH_W-1:0] low;
  logic signed [LH_W-1:0] high;
  logic signed [31:0] rot;

  logic [17:0] a_len;
  logic [17:0] b_len;
  logic [18:0] reach16;

  logic signed [MUL_W-1:0] mul_a;
  logic signed [MUL_W-1:0] mul_b;
  logic signed [PROD_W-1:0] prod;
  logic [PROD_W-1:0] prod_abs;
  logic [ACC_W-1:0] acc_abs;

  logic [SQ_W-1:0] sq_sum;
  logic sq_ge;
  logic [SQ_W-1:0] sq_v_next;
  logic [SQ_W-1:0] sq_r_next;

  logic [40:0] div_rs;
  logic div_ge;

  logic signed [28:0] cdx;
  logic signed [28:0] cdy;
  logic signed [ANG_W-1:0] catan;

  logic signed [LH_W-1:0] low_v;
  logic signed [LH_W-1:0] high_v;
  logic signed [43:0] rq;
  logic signed [43:0] rt;

  function automatic logic signed [16:0] to_q13(input logic signed [LH_W-1:0] v);
    logic signed [LH_W-1:0] t;
    t = (v + LH_W'(1024)) >>> 11;
    if (t > LH_W'(65535)) return 17'sd65535;
    if (t < -LH_W'(65536)) return -17'sd65536;
    return t[16:0];
  endfunction

  assign a_len = {cfg.upper, 4'b0};
  assign b_len = {cfg.lower, 4'b0};
  assign reach16 = {cfg.reach, 4'b0};
  assign q_pop = (state == S_IDLE) && !q_empty;

  always_comb begin
    case (state) inside
      S_SQX: begin mul_a = MUL_W'(xs); mul_b = MUL_W'(xs); end
      S_SQY: begin mul_a = MUL_W'(ys); mul_b = MUL_W'(ys); end
      S_N1A, S_N2C: begin
        mul_a = MUL_W'($signed({1'b0, d})); mul_b = MUL_W'($signed({1'b0, d}));
      end
      S_N1B, S_N2A: begin
        mul_a = MUL_W'($signed({1'b0, a_len})); mul_b = MUL_W'($signed({1'b0, a_len}));
      end
      S_N1C, S_N2B: begin
        mul_a = MUL_W'($signed({1'b0, b_len})); mul_b = MUL_W'($signed({1'b0, b_len}));
      end
      S_DEN1: begin
        mul_a = MUL_W'($signed({1'b0, d})); mul_b = MUL_W'($signed({1'b0, a_len}));
      end
      S_DEN2: begin
        mul_a = MUL_W'($signed({1'b0, a_len})); mul_b = MUL_W'($signed({1'b0, b_len}));
      end
      S_ACSQ: begin mul_a = MUL_W'(r); mul_b = MUL_W'(r); end
      S_GEARM: begin mul_a = low; mul_b = MUL_W'(33); end
      S_LIFTM: begin mul_a = MUL_W'(zs); mul_b = Q24_TWO_PI; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  always_comb begin
    prod = mul_a * mul_b;
    prod_abs = prod[PROD_W-1] ? PROD_W'(-prod) : PROD_W'(prod);
    acc_abs = acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);

    sq_sum = sq_r + sq_b;
    sq_ge = sq_v >= sq_sum;
    sq_v_next = sq_ge ? sq_v - sq_sum : sq_v;
    sq_r_next = sq_ge ? (sq_r >> 1) + sq_b : sq_r >> 1;

    div_rs = {rem[39:0], ds[41]};
    div_ge = div_rs >= {1'b0, dvs};

    gear_prod = 63'(gear_q) * 63'(GEAR_RECIP);

    cdx = cy >>> ci;
    cdy = cx >>> ci;
    catan = $signed({3'b0, ATAN_TAB[ci]});

    low_v = LH_W'(d1) + LH_W'(d2) - LH_W'(Q24_HALF_PI);
    high_v = LH_W'(e) - LH_W'(Q24_PI);

    rq = div_neg ? -$signed({2'b0, ds}) : $signed({2'b0, ds});
    rt = (rq + 44'sd1024) >>> 11;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (state == S_FIN && (!out_valid || pop)) out_valid <= 1'b1;
      else if (pop && out_valid) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (!q_empty) begin
            xs <= q_item.x;
            ys <= q_item.y;
            zs <= q_item.z;
            side <= q_item.side;
            reach_flag <= 1'b0;
            cos_flag <= 1'b0;
            state <= S_SQX;
          end
        end
        S_SQX: begin
          acc <= ACC_W'(prod);
          state <= S_SQY;
        end
        S_SQY: begin
          sq_v <= {SQ_W'(acc + ACC_W'(prod))} << 8;
          sq_r <= '0;
          sq_b <= SQ_W'(1) << 38;
          sq_first <= 1'b1;
          state <= S_SQRT;
        end
        S_SQRT: begin
          sq_v <= sq_v_next;
          sq_r <= sq_r_next;
          sq_b <= sq_b >> 2;
          if (sq_b == SQ_W'(1)) state <= sq_first ? S_DCLAMP : S_ACCS;
        end
        S_DCLAMP: begin
          if (sq_r > SQ_W'(reach16)) begin
            d <= 20'(reach16 - 1'b1);
            reach_flag <= 1'b1;
          end else if (sq_r == '0) begin
            d <= 20'd1;
            cos_flag <= 1'b1;
          end else begin
            d <= sq_r[19:0];
          end
          state <= S_N1A;
        end
        S_N1A: begin acc <= ACC_W'(prod); state <= S_N1B; end
        S_N1B: begin acc <= acc + ACC_W'(prod); state <= S_N1C; end
        S_N1C: begin acc <= acc - ACC_W'(prod); state <= S_DEN1; end
        S_DEN1: begin
          den <= {prod[38:0], 1'b0};
          cjob <= CJ_D2;
          state <= S_ACHK;
        end
        S_N2A: begin acc <= ACC_W'(prod); state <= S_N2B; end
        S_N2B: begin acc <= acc + ACC_W'(prod); state <= S_N2C; end
        S_N2C: begin acc <= acc - ACC_W'(prod); state <= S_DEN2; end
        S_DEN2: begin
          den <= {prod[38:0], 1'b0};
          cjob <= CJ_E;
          state <= S_ACHK;
        end
        S_ACHK: begin
          div_neg <= acc[ACC_W-1];
          if (acc_abs >= ACC_W'({den, 1'b0})) begin
            r <= acc[ACC_W-1] ? -26'($signed({1'b0, Q24_ONE})) : 26'($signed({1'b0, Q24_ONE}));
            cos_flag <= 1'b1;
            state <= S_ACSQ;
          end else begin
            rem <= 41'(acc_abs >> 1);
            ds <= {acc_abs[0], 41'b0};
            dvs <= den;
            dcnt <= 6'd25;
            djob <= DJ_COS;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          rem <= div_ge ? div_rs - {1'b0, dvs} : div_rs;
          ds <= {ds[40:0], div_ge};
          dcnt <= dcnt - 1'b1;
          if (dcnt == 6'd1) begin
            unique case (djob)
              DJ_COS: state <= S_ACQ;
              DJ_LIFT: state <= S_LIFTQ;
              default: state <= S_ACQ;
            endcase
          end
        end
        S_ACQ: begin
          if (ds[24:0] > Q24_ONE) begin
            r <= div_neg ? -26'($signed({1'b0, Q24_ONE})) : 26'($signed({1'b0, Q24_ONE}));
            cos_flag <= 1'b1;
          end else begin
            r <= div_neg ? -$signed({1'b0, ds[24:0]}) : $signed({1'b0, ds[24:0]});
          end
          state <= S_ACSQ;
        end
        S_ACSQ: begin
          sq_v <= SQ_W'(ONE_SQ - ACC_W'(prod));
          sq_r <= '0;
          sq_b <= SQ_W'(1) << 48;
          sq_first <= 1'b0;
          state <= S_SQRT;
        end
        S_ACCS: begin
          cx <= 29'(r);
          cy <= $signed({4'b0, sq_r[24:0]});
          state <= S_CINIT;
        end
        S_CINIT: begin
          ci <= '0;
          if (cx == '0 && cy == '0) begin
            cz <= '0;
            state <= S_CDONE;
          end else begin
            if (cx < 0) begin
              if (cy >= 0) begin
                cx <= cy;
                cy <= -cx;
                cz <= Q24_HALF_PI;
              end else begin
                cx <= -cy;
                cy <= cx;
                cz <= -Q24_HALF_PI;
              end
            end else begin
              cz <= '0;
            end
            state <= S_CORD;
          end
        end
        S_CORD: begin
          if (cy > 0) begin
            cx <= cx + cdx;
            cy <= cy - cdy;
            cz <= cz + catan;
          end else begin
            cx <= cx - cdx;
            cy <= cy + cdy;
            cz <= cz - catan;
          end
          ci <= ci + 1'b1;
          if (ci == 5'(CORDIC_STEPS - 1)) state <= S_CDONE;
        end
        S_CDONE: begin
          unique case (cjob)
            CJ_D2: begin
              d2 <= cz;
              state <= S_N2A;
            end
            CJ_E: begin
              e <= cz;
              cx <= 29'(xs) <<< 8;
              cy <= 29'(ys) <<< 8;
              cjob <= CJ_D1;
              state <= S_CINIT;
            end
            CJ_D1: begin
              d1 <= cz;
              state <= S_ANG;
            end
            default: state <= S_ANG;
          endcase
        end
        S_ANG: begin
          low <= side ? -low_v : low_v;
          high <= side ? -high_v : high_v;
          state <= S_GEARM;
        end
        S_GEARM: begin
          // |low * 33| stays below 2^32; halve it, then divide by 31
          div_neg <= prod[PROD_W-1];
          gear_q <= prod_abs[31:1];
          state <= S_GEARQ;
        end
        S_GEARQ: begin
          high <= div_neg ? high - $signed({4'b0, gear_prod[61:36]})
                          : high + $signed({4'b0, gear_prod[61:36]});
          state <= S_LIFTM;
        end
        S_LIFTM: begin
          div_neg <= prod[PROD_W-1];
          rem <= '0;
          ds <= prod_abs[41:0];
          dvs <= 40'(cfg.lead);
          dcnt <= 6'd42;
          djob <= DJ_LIFT;
          state <= S_DIV;
        end
        S_LIFTQ: begin
          if (rt > 44'sd2147483647) rot <= 32'sh7fffffff;
          else if (rt < -44'sd2147483648) rot <= 32'sh80000000;
          else rot <= rt[31:0];
          state <= S_FIN;
        end
        S_FIN: begin
          if (!out_valid || pop) begin
            shoulder_angle <= to_q13(low);
            elbow_angle <= to_q13(high);
            lift_rotation <= rot;
            elbow_flipped <= side;
            reach_clamped <= reach_flag;
            cosine_clamped <= cos_flag;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> design/two_link_arm_inverse_kinematics.sv
// Each item runs alone through the shared sequencer (bit-serial square roots,
// restoring divider for cosine ratios and lift, 16-step CORDIC). A cosine ratio
// of twice its denominator or more skips the divider; a target at the origin
// skips the shoulder-direction CORDIC. A held result stalls the sequencer; a
// new item is taken only once the last result is registered. A 2-item queue and
// the result register let input and output run ahead. Reset (rst, synchronous)
// clears the queue, the result, the elbow side and loads the register defaults.
module two_link_arm_inverse_kinematics
  import ik_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  logic signed [15:0]  x_pos,
  input  logic signed [15:0]  y_pos,
  input  logic signed [15:0]  z_pos,
  output logic                empty,
  input  logic                pop,
  output logic signed [16:0]  shoulder_angle,
  output logic signed [16:0]  elbow_angle,
  output logic signed [31:0]  lift_rotation,
  output logic                elbow_flipped,
  output logic                reach_clamped,
  output logic                cosine_clamped,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [14:0]         cfg_data
);

  localparam logic [1:0] REG_UPPER = 2'd0;
  localparam logic [1:0] REG_LOWER = 2'd1;
  localparam logic [1:0] REG_LEAD = 2'd2;
  localparam logic [1:0] REG_PARK = 2'd3;

  logic [13:0] upper_link_length;
  logic [13:0] lower_link_length;
  logic [11:0] screw_lead;
  logic [14:0] park_x_threshold;
  cfg_t cfg;

  logic q_push;
  item_t q_wr_item;
  logic q_empty;
  logic q_pop;
  item_t q_rd_item;
  logic out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      upper_link_length <= 14'd1600;
      lower_link_length <= 14'd1600;
      screw_lead <= 12'd128;
      park_x_threshold <= 15'd2160;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_UPPER: upper_link_length <= cfg_data[13:0];
        REG_LOWER: lower_link_length <= cfg_data[13:0];
        REG_LEAD: screw_lead <= cfg_data[11:0];
        REG_PARK: park_x_threshold <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.upper = (upper_link_length == '0) ? 14'd1 : upper_link_length;
    cfg.lower = (lower_link_length == '0) ? 14'd1 : lower_link_length;
    cfg.lead = (screw_lead == '0) ? 12'd1 : screw_lead;
    cfg.reach = {1'b0, cfg.upper} + {1'b0, cfg.lower};
    cfg.park = park_x_threshold;
  end

  ik_front u_front (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .x_pos  (x_pos),
    .y_pos  (y_pos),
    .z_pos  (z_pos),
    .cfg    (cfg),
    .q_push (q_push),
    .q_item (q_wr_item)
  );

  ik_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_push),
    .wr_item (q_wr_item),
    .full    (full),
    .rd_en   (q_pop),
    .rd_item (q_rd_item),
    .empty   (q_empty)
  );

  ik_back u_back (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .q_empty        (q_empty),
    .q_item         (q_rd_item),
    .q_pop          (q_pop),
    .pop            (pop),
    .out_valid      (out_valid),
    .shoulder_angle (shoulder_angle),
    .elbow_angle    (elbow_angle),
    .lift_rotation  (lift_rotation),
    .elbow_flipped  (elbow_flipped),
    .reach_clamped  (reach_clamped),
    .cosine_clamped (cosine_clamped)
  );

  assign empty = !out_valid;

endmodule

>>> tb/ik_tb_pkg.sv
package ik_tb_pkg;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [1:0] {
    REG_UPPER = 2'd0,
    REG_LOWER = 2'd1,
    REG_LEAD  = 2'd2,
    REG_PARK  = 2'd3
  } cfg_reg_e;

  typedef struct {
    logic signed [16:0] shoulder;
    logic signed [16:0] elbow;
    logic signed [31:0] lift;
    logic               flipped;
    logic               reach_clamp;
    logic               cos_clamp;
  } joint_cmd_t;
endpackage

>>> tb/ik_checker.sv
module ik_checker
  import ik_pkg::*;
  import ik_tb_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  logic               full,
  input  logic signed [15:0] x_pos,
  input  logic signed [15:0] y_pos,
  input  logic signed [15:0] z_pos,
  input  logic               empty,
  input  logic               pop,
  input  logic signed [16:0] shoulder_angle,
  input  logic signed [16:0] elbow_angle,
  input  logic signed [31:0] lift_rotation,
  input  logic               elbow_flipped,
  input  logic               reach_clamped,
  input  logic               cosine_clamped,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [14:0]        cfg_data,
  output int                 pending,
  output int                 errors
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint ONE = 64'sd16777216;

  logic [13:0] upper_len, lower_len;
  logic [11:0] lead_len;
  logic [14:0] park_thr;
  logic        side;
  joint_cmd_t  joint_q[$];

  function automatic longint isqrt64(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return longint'(r);
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint cordic_atan2(longint y, longint x);
    longint z, t, dx, dy;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t; z = longint'(Q24_HALF_PI);
      end else begin
        t = x; x = -y; y = t; z = -longint'(Q24_HALF_PI);
      end
    end
    for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x += dx; y -= dy; z += longint'(ATAN_TAB[i]);
      end else begin
        x -= dx; y += dy; z -= longint'(ATAN_TAB[i]);
      end
    end
    return z;
  endfunction

  function automatic longint law_of_cos(longint num, longint den, inout logic flag);
    longint r;
    r = (num * ONE) / den;
    if (r > ONE) begin r = ONE; flag = 1; end
    if (r < -ONE) begin r = -ONE; flag = 1; end
    return cordic_atan2(isqrt64(longint'(ONE * ONE - r * r)), r);
  endfunction

  function automatic longint to_q13(longint v);
    return clip((v + 1024) >>> 11, -65536, 65535);
  endfunction

  function automatic joint_cmd_t solve_joints(longint x, longint y, longint z);
    joint_cmd_t c;
    longint l1, l2, lead, reach, d, a, b, d1, d2, e, lo, hi, rq;
    logic rflag, cflag;
    l1 = upper_len != 0 ? longint'(upper_len) : 1;
    l2 = lower_len != 0 ? longint'(lower_len) : 1;
    lead = lead_len != 0 ? longint'(lead_len) : 1;
    reach = l1 + l2;
    rflag = 0;
    cflag = 0;
    d = isqrt64(longint'(x * x + y * y) * 256);
    if (d > reach * 16) begin
      d = reach * 16 - 1;
      rflag = 1;
    end
    if (d == 0) begin
      d = 1;
      cflag = 1;
    end
    if (x > 0 && y < reach) side = 0;
    if (x > longint'(park_thr)) side = 0;
    if (x < 0 && y < reach) side = 1;
    if (side) x = -x;
    a = l1 * 16;
    b = l2 * 16;
    d1 = cordic_atan2(y * 256, x * 256);
    d2 = law_of_cos(d * d + a * a - b * b, 2 * d * a, cflag);
    e = law_of_cos(a * a + b * b - d * d, 2 * a * b, cflag);
    lo = d1 + d2 - longint'(Q24_HALF_PI);
    hi = e - longint'(Q24_PI);
    if (side) begin
      lo = -lo;
      hi = -hi;
    end
    hi += (lo * 33) / 62;
    rq = (z * longint'(Q24_TWO_PI)) / lead;
    c.shoulder = to_q13(lo);
    c.elbow = to_q13(hi);
    c.lift = clip((rq + 1024) >>> 11, -64'sd2147483648, 64'sd2147483647);
    c.flipped = side;
    c.reach_clamp = rflag;
    c.cos_clamp = cflag;
    return c;
  endfunction

  always @(posedge clk) begin
    joint_cmd_t want;
    if (rst) begin
      upper_len = 14'd1600;
      lower_len = 14'd1600;
      lead_len = 12'd128;
      park_thr = 15'd2160;
      side = 0;
      joint_q.delete();
      errors = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_reg_e'(cfg_index))
          REG_UPPER: upper_len = cfg_data[13:0];
          REG_LOWER: lower_len = cfg_data[13:0];
          REG_LEAD:  lead_len = cfg_data[11:0];
          REG_PARK:  park_thr = cfg_data;
        endcase
      end
      if (push && !full)
        joint_q.push_back(solve_joints(x_pos, y_pos, z_pos));
      if (pop && !empty) begin
        if (joint_q.size() == 0) begin
          $display("%0t: unexpected item sh=%0d el=%0d", $time, shoulder_angle, elbow_angle);
          errors++;
        end else begin
          want = joint_q.pop_front();
          if (shoulder_angle !== want.shoulder || elbow_angle !== want.elbow ||
              lift_rotation !== want.lift || elbow_flipped !== want.flipped ||
              reach_clamped !== want.reach_clamp || cosine_clamped !== want.cos_clamp) begin
            $display("%0t: expected sh=%0d el=%0d lift=%0d flip=%b rc=%b cc=%b", $time,
                     want.shoulder, want.elbow, want.lift, want.flipped,
                     want.reach_clamp, want.cos_clamp);
            $display("%0t: actual   sh=%0d el=%0d lift=%0d flip=%b rc=%b cc=%b", $time,
                     shoulder_angle, elbow_angle, lift_rotation, elbow_flipped,
                     reach_clamped, cosine_clamped);
            errors++;
          end
        end
      end
    end
    pending = joint_q.size();
  end
endmodule

>>> tb/tb_top.sv
module tb_top;
  import ik_tb_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 20000;

  logic clk = 0, rst = 1;
  logic push = 0, pop = 0, cfg_we = 0;
  logic signed [15:0] x_pos = 0, y_pos = 0, z_pos = 0;
  logic [1:0] cfg_index = 0;
  logic [14:0] cfg_data = 0;
  logic full, empty, elbow_flipped, reach_clamped, cosine_clamped;
  logic signed [16:0] shoulder_angle, elbow_angle;
  logic signed [31:0] lift_rotation;
  int pending, errors, quiet;
  bit idle_on = 1, hold_req = 0;
  int reach_now = 3200;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  two_link_arm_inverse_kinematics dut (.*);
  ik_checker chk (.*);

  always @(posedge clk) begin
    if (rst || push && !full || pop && !empty) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    int hold;
    forever begin
      @(negedge clk);
      if (hold_req && !rst) begin
        pop = 0;
        for (hold = 0; hold < 1500; hold++) @(negedge clk);
        hold_req = 0;
      end
      pop = !rst && (!idle_on || $urandom_range(99) >= 10);
    end
  end

  task automatic send(input logic [15:0] x, y, z);
    while (idle_on && $urandom_range(99) < 10) begin
      push = 0;
      @(negedge clk);
    end
    push = 1;
    x_pos = x;
    y_pos = y;
    z_pos = z;
    do @(posedge clk); while (full);
    @(negedge clk);
    push = 0;
  endtask

  task automatic drain();
    push = 0;
    while (pending != 0) @(negedge clk);
    repeat (300) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [14:0] val);
    cfg_we = 1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 0;
  endtask

  task automatic set_arm(input int up, lo, lead, park);
    write_reg(REG_UPPER, 15'(up));
    write_reg(REG_LOWER, 15'(lo));
    write_reg(REG_LEAD, 15'(lead));
    write_reg(REG_PARK, 15'(park));
    reach_now = up + lo;
  endtask

  task automatic random_items(input int n);
    int lim, m;
    for (int i = 0; i < n; i++) begin
      lim = reach_now > 32767 ? 32767 : reach_now;
      m = $urandom_range(3);
      if (m == 0) send(16'($urandom), 16'($urandom), 16'($urandom));
      else send(16'($urandom_range(2 * lim) - lim), 16'($urandom_range(2 * lim) - lim),
                16'($urandom));
    end
  endtask

  initial begin
    repeat (8) @(negedge clk);
    rst = 0;
    send(0, 0, 0);
    send(16'sh7fff, 16'sh7fff, 16'sh7fff);
    send(16'sh8000, 16'sh8000, 16'sh8000);
    send(16'sh7fff, 16'sh8000, 16'sh0001);
    send(16'sh8000, 16'sh7fff, 16'shffff);
    send(-100, 50, 1000);
    send(100, 50, -1000);
    send(-100, 50, 0);
    send(2200, 3500, 5);
    send(-2000, 0, 7);
    send(0, 1000, 3);
    send(3000, 0, 2);
    send(1, 0, 0);
    send(0, -1, 0);
    send(-1, 0, 0);
    send(0, 3200, 0);
    send(-3199, 0, 0);
    random_items(60);
    hold_req = 1;
    random_items(90);
    drain();
    set_arm(1, 16383, 4095, 0);
    send(0, 0, 16'sh7fff);
    send(10, 0, 16'sh8000);
    send(-10, 0, 1);
    send(16383, 0, 0);
    random_items(120);
    drain();
    set_arm(16383, 16383, 1, 32767);
    send(16'sh8000, 16'sh8000, 16'sh7fff);
    send(16'sh7fff, 0, 16'sh8000);
    idle_on = 0;
    random_items(140);
    idle_on = 1;
    drain();
    set_arm(16383, 1, 1, 16383);
    send(0, 0, 0);
    send(5, 5, 5);
    random_items(40);
    drain();
    for (int p = 0; p < 3; p++) begin
      set_arm($urandom_range(1, 16383), $urandom_range(1, 16383),
              $urandom_range(1, 4095), $urandom_range(0, 32767));
      random_items(60);
      drain();
    end
    set_arm(1600, 1600, 128, 2160);
    random_items(20);
    drain();
    if (errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule

>>> two_link_arm_inverse_kinematics.f
design/ik_pkg.sv
design/ik_front.sv
design/ik_queue.sv
design/ik_back.sv
design/two_link_arm_inverse_kinematics.sv
tb/ik_tb_pkg.sv
tb/ik_checker.sv
tb/tb_top.sv
